// ===== rtl/core/b32e_pkg.sv =====
// Shared types, constants and helpers for the Base32 stream encoder.
package b32e_pkg;

   localparam logic       CMD_DATA = 1'b0;
   localparam logic       CMD_END  = 1'b1;
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified item: up to two alphabet characters, then pads.
   typedef struct packed {
      logic       is_end;
      logic [7:0] char0;
      logic [7:0] char1;
      logic [1:0] num_chars;
      logic [2:0] num_pads;
   } job_type;

   // Standard alphabet: A..Z, then 2..7.
   function automatic logic [7:0] b32_char(input logic [4:0] v);
      logic [7:0] ch;
      if (v < 5'd26) begin
         ch = 8'h41 + {3'b000, v};
      end else begin
         ch = 8'h18 + {3'b000, v};
      end
      return ch;
   endfunction

endpackage

// ===== rtl/core/b32e_front.sv =====
// Front end: accepts items, holds the bit carry and char count, builds jobs.
module b32e_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_cmd,
   input  logic [7:0]       req_data_byte,
   input  logic             queue_full,
   output logic             push,
   output b32e_pkg::job_type push_job
);
   import b32e_pkg::*;

   logic [3:0]  leftover_bits_ff, leftover_bits_in;
   logic [2:0]  leftover_count_ff, leftover_count_in;
   logic [2:0]  chars_mod_eight_ff, chars_mod_eight_in;

   logic        accept;
   logic [11:0] acc;
   logic [11:0] grp0_shift, grp1_shift;
   logic [2:0]  data_count;
   logic [4:0]  keep_mask;
   logic [8:0]  flush_shift;
   logic [1:0]  nchars;
   logic [2:0]  mod_after;
   logic [2:0]  pads;
   job_type     job;

   assign accept    = req_valid && !queue_full;
   assign req_stall = queue_full;

   always_comb begin
      acc         = {leftover_bits_ff, req_data_byte};
      grp0_shift  = acc >> (leftover_count_ff + 3'd3);
      grp1_shift  = acc >> (leftover_count_ff - 3'd2);
      flush_shift = {5'b00000, leftover_bits_ff} << (3'd5 - leftover_count_ff);

      if (leftover_count_ff < 3'd2) begin
         data_count = leftover_count_ff + 3'd3;
      end else begin
         data_count = leftover_count_ff - 3'd2;
      end
      keep_mask = (5'd1 << data_count) - 5'd1;

      job = '0;
      pads = 3'd0;
      nchars = 2'd0;
      mod_after = 3'd0;
      if (req_cmd == CMD_DATA) begin
         nchars        = (leftover_count_ff < 3'd2) ? 2'd1 : 2'd2;
         job.is_end    = 1'b0;
         job.char0     = b32_char(grp0_shift[4:0]);
         job.char1     = b32_char(grp1_shift[4:0]);
         job.num_chars = nchars;
         job.num_pads  = 3'd0;
      end else begin
         nchars    = (leftover_count_ff != 3'd0) ? 2'd1 : 2'd0;
         mod_after = chars_mod_eight_ff + {1'b0, nchars};
         if (mod_after != 3'd0) begin
            pads = 3'(4'd8 - {1'b0, mod_after});
         end
         // at most seven results per item
         if (nchars == 2'd1 && pads == 3'd7) begin
            pads = 3'd6;
         end
         job.is_end    = 1'b1;
         job.char0     = b32_char(flush_shift[4:0]);
         job.char1     = PAD_CHAR;
         job.num_chars = nchars;
         job.num_pads  = pads;
      end

      leftover_bits_in   = leftover_bits_ff;
      leftover_count_in  = leftover_count_ff;
      chars_mod_eight_in = chars_mod_eight_ff;
      if (accept) begin
         if (req_cmd == CMD_DATA) begin
            leftover_bits_in   = req_data_byte[3:0] & keep_mask[3:0];
            leftover_count_in  = data_count;
            chars_mod_eight_in = chars_mod_eight_ff + {1'b0, nchars};
         end else begin
            leftover_bits_in   = 4'd0;
            leftover_count_in  = 3'd0;
            chars_mod_eight_in = 3'd0;
         end
      end
   end

   // an end item with nothing to emit (empty message, or a length that is a multiple of five bytes) makes no job
   assign push     = accept && (job.num_chars != 2'd0 || job.num_pads != 3'd0);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_bits_ff   <= '0;
         leftover_count_ff  <= '0;
         chars_mod_eight_ff <= '0;
      end else begin
         leftover_bits_ff   <= leftover_bits_in;
         leftover_count_ff  <= leftover_count_in;
         chars_mod_eight_ff <= chars_mod_eight_in;
      end
   end

endmodule

// ===== rtl/core/b32e_queue.sv =====
// Short job queue between the front end and the character sequencer.
module b32e_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b32e_pkg::job_type push_job,
   input  logic              pop,
   output logic              head_valid,
   output b32e_pkg::job_type head_job,
   output logic              full
);
   import b32e_pkg::*;

   job_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 do_push, do_pop;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/b32e_back.sv =====
// Back end: feeds the head job to the output register, one char per cycle unless stalled.
module b32e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  b32e_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_last,
   output logic              rsp_message_done
);
   import b32e_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;

   logic [2:0] total;
   logic       final_one;
   logic [7:0] cur_char;
   logic       load;

   always_comb begin
      total     = {1'b0, head_job.num_chars} + head_job.num_pads;
      final_one = (idx_ff == total - 3'd1);
      if (idx_ff < {1'b0, head_job.num_chars}) begin
         cur_char = idx_ff[0] ? head_job.char1 : head_job.char0;
      end else begin
         cur_char = PAD_CHAR;
      end
      load = head_valid && (!rsp_valid_ff || !rsp_stall);

      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         out_char_in  = cur_char;
         last_in      = final_one;
         done_in      = final_one && head_job.is_end;
         idx_in       = final_one ? 3'd0 : idx_ff + 3'd1;
      end
   end

   assign pop = load && final_one;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_char_ff <= out_char_in;
      last_ff     <= last_in;
      done_ff     <= done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = out_char_ff;
   assign rsp_last         = last_ff;
   assign rsp_message_done = done_ff;

endmodule

// ===== rtl/core/base32_stream_encoder_top.sv =====
// Top level of the Base32 stream encoder.
//
// Request channel (req_): one item per handshake, cmd selects a message
// byte or the end of message. Response channel (rsp_): one ASCII character
// per handshake, with last on the final character an input item causes and
// message_done on the final character an end item causes (none if it causes none).
// A byte gives one or two characters; an end item gives the flush character
// and '=' pads up to a multiple of eight, at most seven characters, or none
// when the message length is a multiple of five bytes, empty included.
// Timing: the front end classifies an item in the cycle it is accepted and
// queues a job; the back end emits one character per cycle from the queue
// head into the output register while the response is not stalled, so the
// first character is valid once its job has passed the queue slot and the
// output register. Output bandwidth sets the rate, so an item that gives
// more characters takes longer than one that gives fewer.
// A stalled response holds its character; the two-entry job queue keeps
// taking items until full, then req_stall rises.
// Reset (synchronous) clears the carry bits, char count, queue and output valid.
module base32_stream_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last,
   output logic       rsp_message_done
);
   import b32e_pkg::*;

   logic    push, pop, head_valid, queue_full;
   job_type push_job, head_job;

   b32e_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_job      (push_job)
   );

   b32e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .full       (queue_full)
   );

   b32e_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_last         (rsp_last),
      .rsp_message_done (rsp_message_done)
   );

endmodule
